FILE: rtl/core/ring_sector_remapper_unit_defines.svh
// Assertion helpers shared by the remapper modules.
`ifndef RING_SECTOR_REMAPPER_UNIT_DEFINES_SVH
`define RING_SECTOR_REMAPPER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RSR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

FILE: rtl/core/rsr_pkg.sv
`timescale 1ns / 1ps

package rsr_pkg;

   // Sector arithmetic width; registers and sector fields follow it.
   localparam int SECTOR_BITS = 48;
   localparam int CNT_W       = 24;
   localparam int STAT_W      = 64;
   localparam int MAP_W       = SECTOR_BITS + 1;

   // Serial modulo operand: offset plus count needs one bit of headroom.
   localparam int MOD_W       = SECTOR_BITS + 1;
   localparam int MOD_STEP_W  = $clog2(MOD_W + 1);
   localparam logic [MOD_STEP_W-1:0] MOD_STEPS = MOD_STEP_W'(MOD_W);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PHYS_START  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RING_CAP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_BEGIN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED     = 2'd3;

   // Request kinds and response status codes.
   localparam logic KIND_MAP      = 1'b0;
   localparam logic KIND_CLEAR    = 1'b1;
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   // Update command from the sequencer to the statistics registers.
   typedef struct packed {
      logic                   clear;
      logic                   add_read;
      logic                   add_write;
      logic [CNT_W-1:0]       count;
      logic [SECTOR_BITS-1:0] pos;
   } rsr_upd_type;

endpackage

FILE: rtl/core/rsr_serial_mod.sv
`timescale 1ns / 1ps
`include "ring_sector_remapper_unit_defines.svh"

// Bit-serial restoring modulo: one dividend bit enters the remainder per cycle.
module rsr_serial_mod (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rsr_pkg::MOD_W-1:0]        operand,
   input  logic [rsr_pkg::SECTOR_BITS-1:0]  divisor,
   output logic                             busy,
   output logic                             done,
   output logic [rsr_pkg::SECTOR_BITS-1:0]  result
);
   import rsr_pkg::*;

   logic [MOD_W-1:0]       dvd_ff, dvd_in;
   logic [SECTOR_BITS-1:0] rem_ff, rem_in;
   logic [SECTOR_BITS-1:0] div_ff, div_in;
   logic [MOD_STEP_W-1:0]  step_ff, step_in;
   logic                   done_ff, done_in;

   logic [SECTOR_BITS:0]   trial;
   logic [SECTOR_BITS:0]   diff;
   logic                   fits;

   // One restoring step: shift in the next bit, subtract if it fits.
   always_comb begin
      trial = {rem_ff, dvd_ff[MOD_W-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = trial >= {1'b0, div_ff};
   end

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = operand;
         rem_in  = '0;
         div_in  = divisor;
         step_in = MOD_STEPS;
      end else if (step_ff != '0) begin
         dvd_in  = {dvd_ff[MOD_W-2:0], 1'b0};
         rem_in  = fits ? diff[SECTOR_BITS-1:0] : trial[SECTOR_BITS-1:0];
         step_in = step_ff - MOD_STEP_W'(1);
         done_in = (step_ff == MOD_STEP_W'(1));
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   // Datapath shift registers
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy   = step_ff != '0;
   assign done   = done_ff;
   assign result = rem_ff;

   `RSR_ASSERT_IMP(a_rem_below_div, clock, reset, done_ff, rem_ff < div_ff)
   `RSR_ASSERT_IMP(a_no_restart, clock, reset, start, step_ff == '0)
   `RSR_ASSERT_IMP(a_done_idle, clock, reset, done_ff, step_ff == '0)

endmodule

FILE: rtl/core/rsr_state_regs.sv
`timescale 1ns / 1ps

// Write position and wrapping statistics counters.
module rsr_state_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  rsr_pkg::rsr_upd_type             upd,
   output logic [rsr_pkg::SECTOR_BITS-1:0]  position,
   output logic [rsr_pkg::STAT_W-1:0]       wr_total,
   output logic [rsr_pkg::STAT_W-1:0]       rd_total,
   output logic [rsr_pkg::STAT_W-1:0]       sector_total
);
   import rsr_pkg::*;

   logic [SECTOR_BITS-1:0] pos_ff, pos_in;
   logic [STAT_W-1:0]      wr_ff, wr_in;
   logic [STAT_W-1:0]      rd_ff, rd_in;
   logic [STAT_W-1:0]      sec_ff, sec_in;

   // Clear wins; otherwise one read or one write update per beat
   always_comb begin
      pos_in = pos_ff;
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      sec_in = sec_ff;
      priority if (upd.clear) begin
         pos_in = '0;
         wr_in  = '0;
         rd_in  = '0;
         sec_in = '0;
      end else if (upd.add_write) begin
         pos_in = upd.pos;
         wr_in  = wr_ff + STAT_W'(1);
         sec_in = sec_ff + STAT_W'(upd.count);
      end else if (upd.add_read) begin
         rd_in  = rd_ff + STAT_W'(1);
      end else begin
         // no update: hold
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         wr_ff  <= '0;
         rd_ff  <= '0;
         sec_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         sec_ff <= sec_in;
      end
   end

   assign position     = pos_ff;
   assign wr_total     = wr_ff;
   assign rd_total     = rd_ff;
   assign sector_total = sec_ff;

endmodule

FILE: rtl/core/ring_sector_remapper_unit.sv
// A clear or rejected beat goes straight to the response register; a read map first
// takes one modulo pass and a write map two (offset, then wrap) in the shared
// bit-serial divider. One beat is in flight; the next request can be taken in the
// cycle after the response register loads, even while it stalls. Reset (synchronous,
// active high) clears the position, counters and control, and sets capacity to 1
// and enabled to 1.
`timescale 1ns / 1ps
`include "ring_sector_remapper_unit_defines.svh"

module ring_sector_remapper_unit (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_write_en,
   input  logic [rsr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rsr_pkg::SECTOR_BITS-1:0]  csr_write_data,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_kind,
   input  logic [rsr_pkg::SECTOR_BITS-1:0]  req_logical_sector,
   input  logic [rsr_pkg::CNT_W-1:0]        req_sector_count,
   input  logic                             req_is_write,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_status,
   output logic [rsr_pkg::MAP_W-1:0]        rsp_mapped_sector,
   output logic [rsr_pkg::SECTOR_BITS-1:0]  rsp_write_position,
   output logic [rsr_pkg::STAT_W-1:0]       rsp_write_count,
   output logic [rsr_pkg::STAT_W-1:0]       rsp_read_count,
   output logic [rsr_pkg::STAT_W-1:0]       rsp_sectors_written
);
   import rsr_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MAP  = 2'd1;
   localparam logic [1:0] S_WRAP = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   // configuration registers
   logic [SECTOR_BITS-1:0] phys_ff, cap_ff, target_ff;
   logic                   enabled_ff;

   // sequencer
   logic [1:0]             state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   is_write_ff, is_write_in;
   logic                   status_ff, status_in;
   logic [MAP_W-1:0]       mapped_ff, mapped_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_status_ff;
   logic [MAP_W-1:0]       rsp_mapped_ff;
   logic [SECTOR_BITS-1:0] rsp_pos_ff;
   logic [STAT_W-1:0]      rsp_wr_ff, rsp_rd_ff, rsp_sec_ff;

   logic                   req_accept;
   logic                   rsp_free;
   logic                   rsp_load;
   logic                   rsp_reject;

   logic                   mod_start;
   logic [MOD_W-1:0]       mod_operand;
   logic [SECTOR_BITS-1:0] mod_divisor;
   logic                   mod_busy;
   logic                   mod_done;
   logic [SECTOR_BITS-1:0] mod_result;

   rsr_upd_type            upd;
   logic [SECTOR_BITS-1:0] st_pos;
   logic [STAT_W-1:0]      st_wr, st_rd, st_sec;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         phys_ff    <= '0;
         cap_ff     <= SECTOR_BITS'(1);
         target_ff  <= '0;
         enabled_ff <= 1'b1;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_PHYS_START:   phys_ff    <= csr_write_data;
            CSR_RING_CAP:     cap_ff     <= csr_write_data;
            CSR_TARGET_BEGIN: target_ff  <= csr_write_data;
            CSR_ENABLED:      enabled_ff <= csr_write_data[0];
         endcase
      end
   end

   assign req_stall   = state_ff != S_IDLE;
   assign req_accept  = req_valid && !req_stall;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_load    = (state_ff == S_DONE) && rsp_free;
   assign rsp_reject  = rsp_valid_ff && (rsp_status_ff == STATUS_REJECT);
   // zero capacity acts as one
   assign mod_divisor = (cap_ff == '0) ? SECTOR_BITS'(1) : cap_ff;

   // Sequencer: offset pass, then wrap pass for writes; clears and rejects skip both
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      is_write_in = is_write_ff;
      status_in   = status_ff;
      mapped_in   = mapped_ff;
      mod_start   = 1'b0;
      mod_operand = {1'b0, req_logical_sector - target_ff};
      upd         = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               count_in    = req_sector_count;
               is_write_in = req_is_write;
               status_in   = STATUS_OK;
               mapped_in   = '0;
               priority if (!enabled_ff) begin
                  status_in = STATUS_REJECT;
                  state_in  = S_DONE;
               end else if (req_kind == KIND_CLEAR) begin
                  upd.clear = 1'b1;
                  state_in  = S_DONE;
               end else begin
                  mod_start = 1'b1;
                  state_in  = S_MAP;
               end
            end
         end
         S_MAP: begin
            if (mod_done) begin
               mapped_in = {1'b0, phys_ff} + {1'b0, mod_result};
               if (is_write_ff) begin
                  mod_operand = {1'b0, mod_result} + MOD_W'(count_ff);
                  mod_start   = 1'b1;
                  state_in    = S_WRAP;
               end else begin
                  upd.add_read = 1'b1;
                  state_in     = S_DONE;
               end
            end
         end
         S_WRAP: begin
            if (mod_done) begin
               upd.add_write = 1'b1;
               upd.count     = count_ff;
               upd.pos       = mod_result;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      is_write_ff <= is_write_in;
      status_ff   <= status_in;
      mapped_ff   <= mapped_in;
   end

   rsr_serial_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .operand (mod_operand),
      .divisor (mod_divisor),
      .busy    (mod_busy),
      .done    (mod_done),
      .result  (mod_result)
   );

   rsr_state_regs u_state (
      .clock        (clock),
      .reset        (reset),
      .upd          (upd),
      .position     (st_pos),
      .wr_total     (st_wr),
      .rd_total     (st_rd),
      .sector_total (st_sec)
   );

   // Response register: holds its beat while stalled
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_mapped_ff <= mapped_ff;
         rsp_pos_ff    <= st_pos;
         rsp_wr_ff     <= st_wr;
         rsp_rd_ff     <= st_rd;
         rsp_sec_ff    <= st_sec;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_mapped_sector   = rsp_mapped_ff;
   assign rsp_write_position  = rsp_pos_ff;
   assign rsp_write_count     = rsp_wr_ff;
   assign rsp_read_count      = rsp_rd_ff;
   assign rsp_sectors_written = rsp_sec_ff;

   `RSR_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_accept, state_ff != S_IDLE)
   `RSR_ASSERT_IMP(a_reject_no_map, clock, reset, rsp_reject, rsp_mapped_ff == '0)
   `RSR_ASSERT_IMP(a_done_in_pass, clock, reset, mod_done, state_ff == S_MAP || state_ff == S_WRAP)
   `RSR_ASSERT_IMP(a_idle_div_free, clock, reset, state_ff == S_IDLE, !mod_busy)

endmodule
